// File: design/graph_depth_first_search_core_assert.svh
// Assertion macros used by the checker module of the depth-first search core.
// Depends on nothing; the including file supplies clock, reset and expressions.
`ifndef GRAPH_DEPTH_FIRST_SEARCH_CORE_ASSERT_SVH
`define GRAPH_DEPTH_FIRST_SEARCH_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDFS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GDFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gdfs_pkg.sv
// Package for the depth-first search core: field widths, result kinds,
// micro-operation codes, step names and the control store. No dependencies.
`default_nettype none

package gdfs_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int VERT_W = 5;
  localparam int KIND_W = 2;

  localparam logic [VERT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

  localparam logic [KIND_W-1:0] KIND_VISIT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FOUND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MISSING = 2'd2;

  // Datapath operation carried by one control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_ADJ_RD_A,
    OP_ADJ_WR_A,
    OP_ADJ_RD_B,
    OP_ADJ_WR_B,
    OP_INIT,
    OP_PUSH_START,
    OP_POP,
    OP_VISIT,
    OP_LOAD_CAND,
    OP_PUSH_CAND,
    OP_EMIT_MISS,
    OP_EMIT_FOUND
  } op_t;

  // Branch condition: when true the sequencer takes jmp, otherwise nxt.
  typedef enum logic [3:0] {
    C_NEVER,
    C_SEARCH,
    C_EDGE_BAD,
    C_START_BAD,
    C_START_EQ,
    C_STACK_EMPTY,
    C_HIT,
    C_CAND_ZERO,
    C_CAND_MULTI
  } cond_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_CHK,
    ST_RD_A,
    ST_WR_A,
    ST_RD_B,
    ST_WR_B,
    ST_INIT,
    ST_START_EQ,
    ST_PUSH_START,
    ST_POP,
    ST_VISIT,
    ST_LOAD,
    ST_SCAN,
    ST_MISS,
    ST_FOUND
  } step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } uword_t;

  // Control store: one word per step.
  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    case (s)
      ST_IDLE:       w = '{OP_TAKE,       C_SEARCH,      ST_INIT,  ST_EDGE_CHK};
      ST_EDGE_CHK:   w = '{OP_NOP,        C_EDGE_BAD,    ST_IDLE,  ST_RD_A};
      ST_RD_A:       w = '{OP_ADJ_RD_A,   C_NEVER,       ST_IDLE,  ST_WR_A};
      ST_WR_A:       w = '{OP_ADJ_WR_A,   C_NEVER,       ST_IDLE,  ST_RD_B};
      ST_RD_B:       w = '{OP_ADJ_RD_B,   C_NEVER,       ST_IDLE,  ST_WR_B};
      ST_WR_B:       w = '{OP_ADJ_WR_B,   C_NEVER,       ST_IDLE,  ST_IDLE};
      ST_INIT:       w = '{OP_INIT,       C_START_BAD,   ST_MISS,  ST_START_EQ};
      ST_START_EQ:   w = '{OP_NOP,        C_START_EQ,    ST_FOUND, ST_PUSH_START};
      ST_PUSH_START: w = '{OP_PUSH_START, C_NEVER,       ST_IDLE,  ST_POP};
      ST_POP:        w = '{OP_POP,        C_STACK_EMPTY, ST_MISS,  ST_VISIT};
      ST_VISIT:      w = '{OP_VISIT,      C_HIT,         ST_FOUND, ST_LOAD};
      ST_LOAD:       w = '{OP_LOAD_CAND,  C_CAND_ZERO,   ST_POP,   ST_SCAN};
      ST_SCAN:       w = '{OP_PUSH_CAND,  C_CAND_MULTI,  ST_SCAN,  ST_POP};
      ST_MISS:       w = '{OP_EMIT_MISS,  C_NEVER,       ST_IDLE,  ST_IDLE};
      ST_FOUND:      w = '{OP_EMIT_FOUND, C_NEVER,       ST_IDLE,  ST_IDLE};
      default:       w = '{OP_NOP,        C_NEVER,       ST_IDLE,  ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: design/graph_depth_first_search_core.sv
// Depth-first search core: microcoded sequencer, adjacency memory and search stack.
// Depends on gdfs_pkg for widths, result kinds and the control store.
//
// Usage. Input words arrive on in_valid/in_ready with func, vertex_a and vertex_b.
// A word with func low adds the undirected edge vertex_a - vertex_b; it gives no
// result and is dropped when either end lies outside 1..vertex_count, with the
// count clamped to 2..MAX_VERTICES. A word with func high searches depth first
// from vertex_a for vertex_b and returns one result word (kind visit) per vertex
// popped other than vertex_b, followed by a final word with last set that says
// found or not found. Results leave on out_valid/out_ready through an output
// register, so the sequencer keeps working while a result waits to be taken; it
// only holds when it needs to emit and the register is still full, or while it
// waits for an input word. Candidates are pushed one per scan step through the
// single stack write port.
// A new input word is taken only once the previous one has finished.
// Reset. rst clears the row valid bits (so the graph reads as empty), the stack, the
// visited marks and the output register, and sets vertex_count to 16. The user must
// write vertex_count via cfg_wen/cfg_wdata only while the core is idle (not enforced).
`default_nettype none

module graph_depth_first_search_core #(
  parameter int MAX_VERTICES = gdfs_pkg::MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [gdfs_pkg::VERT_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic [gdfs_pkg::VERT_W-1:0]  vertex_a,
  input  logic [gdfs_pkg::VERT_W-1:0]  vertex_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gdfs_pkg::VERT_W-1:0]  vertex,
  output logic [gdfs_pkg::KIND_W-1:0]  kind,
  output logic                         last
);
  import gdfs_pkg::*;

  localparam int ROW_IDX_W = $clog2(MAX_VERTICES);
  localparam int DEPTH_W   = $clog2(MAX_VERTICES + 1);

  typedef logic [MAX_VERTICES-1:0] row_t;

  localparam row_t ROW_ONE = row_t'(1);

  // Sequencer and configuration.
  step_t                  step;
  step_t                  step_next;
  uword_t                 uw;
  logic [VERT_W-1:0]      vertex_count;

  // Operands of the current word.
  logic [VERT_W-1:0]      a_q;
  logic [VERT_W-1:0]      b_q;

  // Adjacency memory with one valid bit per row; a row never written reads as zero.
  row_t                   adj_mem [MAX_VERTICES];
  row_t                   row_valid;
  row_t                   adj_rd;
  logic                   adj_rv;

  // Search stack and its read register.
  logic [VERT_W-1:0]      stack_mem [MAX_VERTICES];
  logic [DEPTH_W-1:0]     depth;
  logic [VERT_W-1:0]      stk_rd;

  row_t                   visited;
  row_t                   cand;

  // Combinational datapath signals.
  logic [VERT_W-1:0]      n_act;
  row_t                   nmask;
  logic                   a_ok;
  logic                   b_ok;
  logic [ROW_IDX_W-1:0]   a_idx;
  logic [ROW_IDX_W-1:0]   b_idx;
  logic [ROW_IDX_W-1:0]   k_idx;
  row_t                   a_bit;
  row_t                   b_bit;
  row_t                   adj_row;
  row_t                   cand_load;
  logic [ROW_IDX_W-1:0]   pick_idx;
  row_t                   pick_bit;
  logic [VERT_W-1:0]      pick_vertex;
  logic                   hit;
  logic                   out_free;
  logic                   stall;
  logic                   go;
  logic                   cond_true;

  logic                   adj_re;
  logic [ROW_IDX_W-1:0]   adj_raddr;
  logic                   adj_we;
  logic [ROW_IDX_W-1:0]   adj_waddr;
  row_t                   adj_wdata;

  logic                   push_fire;
  logic                   stk_we;
  logic [VERT_W-1:0]      stk_wdata;
  logic                   pop_fire;
  logic [ROW_IDX_W-1:0]   pop_idx;
  logic                   emit_fire;

  assign uw = ucode_rom(step);

  // The vertex count in force is clamped to 2..MAX_VERTICES.
  always_comb begin
    if (vertex_count < VERT_W'(2)) begin
      n_act = VERT_W'(2);
    end else if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      n_act = VERT_W'(MAX_VERTICES);
    end else begin
      n_act = vertex_count;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      nmask[i] = (32'(i) < 32'(n_act));
    end
  end

  assign a_ok  = (a_q != '0) && (a_q <= n_act);
  assign b_ok  = (b_q != '0) && (b_q <= n_act);
  assign a_idx = ROW_IDX_W'(a_q - VERT_W'(1));
  assign b_idx = ROW_IDX_W'(b_q - VERT_W'(1));
  assign k_idx = ROW_IDX_W'(stk_rd - VERT_W'(1));
  assign a_bit = ROW_ONE << a_idx;
  assign b_bit = ROW_ONE << b_idx;

  assign adj_row   = adj_rv ? adj_rd : '0;
  assign cand_load = adj_row & ~visited & nmask;

  // Highest numbered candidate goes on the stack first.
  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (cand[i]) begin
        pick_idx = ROW_IDX_W'(i);
      end
    end
  end

  assign pick_bit    = ROW_ONE << pick_idx;
  assign pick_vertex = VERT_W'(pick_idx) + VERT_W'(1);

  assign hit      = (stk_rd == b_q);
  assign out_free = !out_valid || out_ready;

  // Stall: waiting for an input word, or for room in the output register.
  always_comb begin
    case (uw.op)
      OP_TAKE:       stall = !in_valid;
      OP_EMIT_MISS:  stall = !out_free;
      OP_EMIT_FOUND: stall = !out_free;
      OP_VISIT:      stall = !hit && !out_free;
      default:       stall = 1'b0;
    endcase
  end

  assign go = !stall;

  always_comb begin
    case (uw.cond)
      C_NEVER:       cond_true = 1'b0;
      C_SEARCH:      cond_true = func;
      C_EDGE_BAD:    cond_true = !(a_ok && b_ok);
      C_START_BAD:   cond_true = !a_ok;
      C_START_EQ:    cond_true = (a_q == b_q);
      C_STACK_EMPTY: cond_true = (depth == '0);
      C_HIT:         cond_true = hit;
      C_CAND_ZERO:   cond_true = (cand_load == '0);
      C_CAND_MULTI:  cond_true = ((cand & (cand - ROW_ONE)) != '0);
      default:       cond_true = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    if (stall) begin
      step_next = step;
    end else if (cond_true) begin
      step_next = uw.jmp;
    end else begin
      step_next = uw.nxt;
    end
  end

  // Datapath controls decoded from the current control word.
  always_comb begin
    in_ready  = (uw.op == OP_TAKE);
    adj_re    = 1'b0;
    adj_raddr = k_idx;
    adj_we    = 1'b0;
    adj_waddr = a_idx;
    adj_wdata = adj_row | b_bit;
    push_fire = 1'b0;
    stk_wdata = a_q;
    pop_fire  = 1'b0;
    emit_fire = 1'b0;
    case (uw.op)
      OP_ADJ_RD_A: begin
        adj_re    = 1'b1;
        adj_raddr = a_idx;
      end
      OP_ADJ_WR_A: begin
        adj_we    = 1'b1;
      end
      OP_ADJ_RD_B: begin
        adj_re    = 1'b1;
        adj_raddr = b_idx;
      end
      OP_ADJ_WR_B: begin
        adj_we    = 1'b1;
        adj_waddr = b_idx;
        adj_wdata = adj_row | a_bit;
      end
      OP_PUSH_START: begin
        push_fire = 1'b1;
      end
      OP_POP: begin
        pop_fire  = (depth != '0);
      end
      OP_VISIT: begin
        adj_re    = go && !hit;
        emit_fire = go && !hit;
      end
      OP_PUSH_CAND: begin
        push_fire = (cand != '0);
        stk_wdata = pick_vertex;
      end
      OP_EMIT_MISS: begin
        emit_fire = go;
      end
      OP_EMIT_FOUND: begin
        emit_fire = go;
      end
      default: begin
        adj_re    = 1'b0;
      end
    endcase
  end

  assign stk_we  = push_fire && (32'(depth) < 32'(MAX_VERTICES));
  assign pop_idx = ROW_IDX_W'(depth - DEPTH_W'(1));

  // Adjacency memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rd <= adj_mem[adj_raddr];
    end
  end

  // Stack memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[depth[ROW_IDX_W-1:0]] <= stk_wdata;
    end
    if (pop_fire) begin
      stk_rd <= stack_mem[pop_idx];
    end
  end

  // Operand registers and candidate set.
  always_ff @(posedge clk) begin
    if (uw.op == OP_TAKE && in_valid) begin
      a_q <= vertex_a;
      b_q <= vertex_b;
    end
    if (uw.op == OP_LOAD_CAND) begin
      cand <= cand_load;
    end else if (uw.op == OP_PUSH_CAND) begin
      cand <= cand & ~pick_bit;
    end
  end

  // Control state, visited marks and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_IDLE;
      vertex_count <= VERTEX_COUNT_RESET;
      row_valid    <= '0;
      adj_rv       <= 1'b0;
      depth        <= '0;
      visited      <= '0;
      out_valid    <= 1'b0;
      vertex       <= '0;
      kind         <= KIND_VISIT;
      last         <= 1'b0;
    end else begin
      step <= step_next;
      if (cfg_wen) begin
        vertex_count <= cfg_wdata;
      end
      if (adj_re) begin
        adj_rv <= row_valid[adj_raddr];
      end
      if (adj_we) begin
        row_valid[adj_waddr] <= 1'b1;
      end

      if (uw.op == OP_INIT) begin
        depth   <= '0;
        visited <= '0;
      end else if (stk_we) begin
        depth <= depth + DEPTH_W'(1);
      end else if (pop_fire) begin
        depth <= depth - DEPTH_W'(1);
      end

      // A vertex is marked when it is pushed, even if the stack is full.
      if (uw.op == OP_PUSH_START) begin
        visited <= visited | a_bit;
      end else if (push_fire && uw.op == OP_PUSH_CAND) begin
        visited <= visited | pick_bit;
      end

      if (emit_fire) begin
        out_valid <= 1'b1;
        case (uw.op)
          OP_VISIT: begin
            vertex <= stk_rd;
            kind   <= KIND_VISIT;
            last   <= 1'b0;
          end
          OP_EMIT_FOUND: begin
            vertex <= '0;
            kind   <= KIND_FOUND;
            last   <= 1'b1;
          end
          default: begin
            vertex <= '0;
            kind   <= KIND_MISSING;
            last   <= 1'b1;
          end
        endcase
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/gdfs_checker.sv
// Port checker for the depth-first search core, attached by bind.
// Depends on gdfs_pkg and the assertion macros in graph_depth_first_search_core_assert.svh.
`default_nettype none

`include "graph_depth_first_search_core_assert.svh"

module gdfs_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [gdfs_pkg::VERT_W-1:0]  vertex,
  input wire logic [gdfs_pkg::KIND_W-1:0]  kind,
  input wire logic                         last
);
  import gdfs_pkg::*;

  // A result word is held until the receiver takes it.
  `GDFS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result word dropped while stalled")

  `GDFS_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(vertex) && $stable(kind) && $stable(last), "result word changed while stalled")

  // A visit word carries a real vertex and is never last; an end word carries none.
  `GDFS_ASSERT_SAME(a_kind_shape, clk, rst, out_valid, (kind == KIND_VISIT && !last && vertex != '0) || ((kind == KIND_FOUND || kind == KIND_MISSING) && last && vertex == '0), "malformed result word")

  // The core works on one input word at a time.
  `GDFS_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready, "input taken again before the previous word finished")

endmodule

bind graph_depth_first_search_core gdfs_checker u_gdfs_checker (.*);

`default_nettype wire
